// ----- src/tkps_pkg.sv -----
// tkps_pkg: shared widths, op codes and controller/datapath interface structs
// for the streaming top-k probe snapshot block
// no dependencies
`default_nettype none

package tkps_pkg;

    // fixed field widths
    localparam int DIST_W = 32;
    localparam int ID_W   = 32;
    localparam int RANK_W = 4;
    localparam int K_W    = 5;
    localparam int OP_W   = 2;

    // stream bus widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    // top_k register value after reset
    localparam logic [K_W-1:0] TOP_K_RESET = 5'd10;

    // item kinds carried in s_tuser
    localparam logic [OP_W-1:0] OP_CAND  = 2'd0;
    localparam logic [OP_W-1:0] OP_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;     // drop all held entries
        logic cand;      // insert or replace with the incoming candidate
        logic step_clr;  // restart the walk counter
        logic rotate;    // rotate held entries one place toward slot 0
        logic kth_cap;   // capture slot 0 distance as k-th distance
        logic out_load;  // load the output register
        logic out_void;  // output register gets the empty-store result
    } tkps_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic empty;      // no entries held
        logic step_last;  // walk counter is on the last held entry
    } tkps_stat_t;

endpackage

`default_nettype wire

// ----- src/tkps_ctrl.sv -----
// tkps_ctrl: controller state machine for the top-k snapshot block
// drives tkps_store through command and status structs; uses tkps_pkg
`default_nettype none

module tkps_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [tkps_pkg::OP_W-1:0] s_op,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output tkps_pkg::tkps_cmd_t            cmd,
    input  wire tkps_pkg::tkps_stat_t      stat
);
    import tkps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_VOID
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_free   = !m_valid_reg || m_tready;
        s_tready   = (state_reg == ST_IDLE);
        accept     = s_tvalid && s_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        OP_CAND:  cmd.cand = 1'b1;
                        OP_QUERY: cmd.clear = 1'b1;
                        OP_END: begin
                            if (stat.empty) begin
                                state_next = ST_VOID;
                            end else begin
                                cmd.step_clr = 1'b1;
                                state_next   = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // one full rotation; the largest entry passes slot 0 last
                cmd.rotate  = 1'b1;
                cmd.kth_cap = 1'b1;
                if (stat.step_last) begin
                    cmd.step_clr = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // second rotation, one result per transaction
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.rotate   = 1'b1;
                    if (stat.step_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_VOID: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_void = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = cmd.out_load || (m_valid_reg && !m_tready);
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ----- src/tkps_store.sv -----
// tkps_store: datapath with a row of sorted entry cells, held count, walk
// counter, top_k register and output register; uses tkps_pkg
`default_nettype none

module tkps_store #(
    parameter int MAX_K = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [tkps_pkg::K_W-1:0]    cfg_data,
    input  wire logic [tkps_pkg::DIST_W-1:0] cand_distance,
    input  wire logic [tkps_pkg::ID_W-1:0]   cand_id,
    input  wire tkps_pkg::tkps_cmd_t         cmd,
    output tkps_pkg::tkps_stat_t             stat,
    output logic [tkps_pkg::DIST_W-1:0]      kth_distance,
    output logic                             store_full,
    output logic [tkps_pkg::RANK_W-1:0]      entry_rank,
    output logic [tkps_pkg::ID_W-1:0]        entry_id,
    output logic                             entry_valid,
    output logic                             last
);
    import tkps_pkg::*;

    localparam int CNT_W = $clog2(MAX_K + 1);

    // entries kept ascending by (distance, id) in slots below held count
    logic [DIST_W-1:0] dist_reg  [MAX_K];
    logic [ID_W-1:0]   id_reg    [MAX_K];
    logic [DIST_W-1:0] dist_next [MAX_K];
    logic [ID_W-1:0]   id_next   [MAX_K];

    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  step_inc;
    logic [CNT_W-1:0]  k_eff;
    logic [K_W-1:0]    topk_reg;
    logic [DIST_W-1:0] kth_reg;

    logic [MAX_K-1:0]  slot_valid;
    logic [MAX_K-1:0]  slot_gt;
    logic [MAX_K-1:0]  slot_le;
    logic [MAX_K-1:0]  slot_beats;
    logic              do_ins;
    logic              do_rep;
    logic              wr_en;
    logic              full;

    // top_k saturated to 1..MAX_K
    always_comb begin
        if (topk_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if ({2'b00, topk_reg} > 7'(MAX_K)) begin
            k_eff = CNT_W'(MAX_K);
        end else begin
            k_eff = CNT_W'(topk_reg);
        end
    end

    assign full   = (held_reg >= k_eff);
    assign do_ins = (held_reg < k_eff);
    // some held distance above the candidate means the largest one is too
    assign do_rep = !do_ins && (|slot_beats);
    assign wr_en  = cmd.cand && (do_ins || do_rep);

    // per-slot compares and next value
    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        logic              prev_le;
        logic [DIST_W-1:0] prev_d;
        logic [ID_W-1:0]   prev_i;
        logic              nxt_valid;
        logic [DIST_W-1:0] nxt_d;
        logic [ID_W-1:0]   nxt_i;
        logic              tail;
        logic              ins_here;

        assign slot_valid[i] = (CNT_W'(i) < held_reg);
        assign slot_gt[i]    = slot_valid[i] &&
                               ((dist_reg[i] > cand_distance) ||
                                ((dist_reg[i] == cand_distance) && (id_reg[i] > cand_id)));
        assign slot_le[i]    = slot_valid[i] && !slot_gt[i];
        assign slot_beats[i] = slot_valid[i] && (cand_distance < dist_reg[i]);

        if (i == 0) begin : g_head
            assign prev_le = 1'b1;
            assign prev_d  = cand_distance;
            assign prev_i  = cand_id;
        end else begin : g_body
            assign prev_le = slot_le[i-1];
            assign prev_d  = dist_reg[i-1];
            assign prev_i  = id_reg[i-1];
        end

        if (i == MAX_K - 1) begin : g_end
            assign nxt_valid = 1'b0;
            assign nxt_d     = dist_reg[i];
            assign nxt_i     = id_reg[i];
        end else begin : g_inner
            assign nxt_valid = slot_valid[i+1];
            assign nxt_d     = dist_reg[i+1];
            assign nxt_i     = id_reg[i+1];
        end

        assign tail     = slot_valid[i] && !nxt_valid;
        assign ins_here = !slot_le[i] && prev_le;

        always_comb begin
            dist_next[i] = dist_reg[i];
            id_next[i]   = id_reg[i];
            if (cmd.rotate) begin
                // last held slot takes slot 0, the rest move down one
                if (tail) begin
                    dist_next[i] = dist_reg[0];
                    id_next[i]   = id_reg[0];
                end else begin
                    dist_next[i] = nxt_d;
                    id_next[i]   = nxt_i;
                end
            end else if (wr_en && !slot_le[i]) begin
                // sorted insert; on replace the old tail falls off the end
                if (ins_here) begin
                    dist_next[i] = cand_distance;
                    id_next[i]   = cand_id;
                end else begin
                    dist_next[i] = prev_d;
                    id_next[i]   = prev_i;
                end
            end
        end
    end

    // held count and walk counter
    always_comb begin
        held_next = held_reg;
        if (cmd.clear) begin
            held_next = '0;
        end else if (cmd.cand && do_ins) begin
            held_next = held_reg + CNT_W'(1);
        end
        step_next = step_reg;
        if (cmd.step_clr) begin
            step_next = '0;
        end else if (cmd.rotate) begin
            step_next = step_inc;
        end
    end

    assign step_inc       = step_reg + CNT_W'(1);
    assign stat.empty     = (held_reg == '0);
    assign stat.step_last = (step_inc == held_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            step_reg <= '0;
            topk_reg <= TOP_K_RESET;
        end else begin
            held_reg <= held_next;
            step_reg <= step_next;
            if (cfg_we) begin
                topk_reg <= cfg_data;
            end
        end
    end

    // entry cells
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_K; i++) begin
            dist_reg[i] <= dist_next[i];
            id_reg[i]   <= id_next[i];
        end
    end

    // k-th distance capture and output register
    always_ff @(posedge aclk) begin
        if (cmd.kth_cap) begin
            kth_reg <= dist_reg[0];
        end
        if (cmd.out_load) begin
            if (cmd.out_void) begin
                kth_distance <= '0;
                store_full   <= 1'b0;
                entry_rank   <= '0;
                entry_id     <= '0;
                entry_valid  <= 1'b0;
                last         <= 1'b1;
            end else begin
                kth_distance <= full ? kth_reg : '0;
                store_full   <= full;
                entry_rank   <= RANK_W'(step_reg);
                entry_id     <= id_reg[0];
                entry_valid  <= 1'b1;
                last         <= stat.step_last;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/streaming_top_k_probe_snapshot_core.sv -----
// streaming_top_k_probe_snapshot_core: top level of the streaming top-k block
// instantiates tkps_ctrl and tkps_store; uses tkps_pkg
`default_nettype none

// channel   direction  transaction carries
// s_        in         one item: kind in tuser, candidate distance and id
// m_        out        one snapshot entry, tlast on the final one
// cfg_      in         top_k register write
//
// candidates and query starts are taken directly in idle.
// a cluster end with n held entries runs two passes of the entry rotation:
// the first finds the k-th distance, the second emits one entry per transaction.
// an empty store answers a cluster end with one void entry carrying tlast.
// reset is synchronous and clears the held count; no clearing pass.
// m_tready low holds the emit pass; s_tready stays low until it completes.

module streaming_top_k_probe_snapshot_core #(
    parameter int MAX_K = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // [31:0] cand_distance, [63:32] cand_id
    input  wire logic [tkps_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] op
    input  wire logic [tkps_pkg::S_TUSER_W-1:0]      s_tuser,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [31:0] kth_distance, [35:32] entry_rank, [67:36] entry_id, [71:68] zero
    output logic [tkps_pkg::M_TDATA_W-1:0]           m_tdata,
    // [0] store_full, [1] entry_valid
    output logic [tkps_pkg::M_TUSER_W-1:0]           m_tuser,
    output logic                                     m_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [tkps_pkg::K_W-1:0]            cfg_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready
);
    import tkps_pkg::*;

    tkps_cmd_t         cmd;
    tkps_stat_t        stat;
    logic [DIST_W-1:0] kth_distance;
    logic              store_full;
    logic [RANK_W-1:0] entry_rank;
    logic [ID_W-1:0]   entry_id;
    logic              entry_valid;

    // register writes must arrive only while idle; the block itself does not enforce it
    assign cfg_ready = 1'b1;

    tkps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[OP_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tkps_store #(
        .MAX_K (MAX_K)
    ) u_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .cand_distance (s_tdata[DIST_W-1:0]),
        .cand_id       (s_tdata[DIST_W+ID_W-1:DIST_W]),
        .cmd           (cmd),
        .stat          (stat),
        .kth_distance  (kth_distance),
        .store_full    (store_full),
        .entry_rank    (entry_rank),
        .entry_id      (entry_id),
        .entry_valid   (entry_valid),
        .last          (m_tlast)
    );

    // result packing
    assign m_tdata = {{(M_TDATA_W - DIST_W - RANK_W - ID_W){1'b0}},
                      entry_id, entry_rank, kth_distance};
    assign m_tuser = {entry_valid, store_full};

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking bench for streaming_top_k_probe_snapshot_core
// drives item, result and top_k write channels; predicts snapshots in-bench
// depends on src/tkps_pkg.sv and the core RTL
`timescale 1ns / 1ps

module tb;

    localparam int MAX_K = 16;

    // op code with no meaning, the core ignores it
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] cand_dist;
        logic [31:0] id;
    } probe_item_t;

    typedef struct packed {
        logic [31:0] kth;
        logic        full;
        logic [3:0]  rank;
        logic [31:0] id;
        logic        valid;
        logic        is_last;
    } snap_entry_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [4:0]  cfg_data  = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    // bench-side copy of the candidate store
    logic [31:0] hold_dist [MAX_K];
    logic [31:0] hold_id   [MAX_K];
    int          hold_cnt = 0;
    logic [4:0]  k_reg    = tkps_pkg::TOP_K_RESET;

    probe_item_t item_q[$];
    snap_entry_t snapshot_q[$];
    int          mismatch_cnt = 0;
    int          tx_gap = 0;
    int          rx_stall = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    streaming_top_k_probe_snapshot_core #(.MAX_K(MAX_K)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always #10 aclk = ~aclk;

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // register value saturated to 1..MAX_K
    function automatic int kept_k();
        int k;
        k = k_reg;
        if (k < 1) k = 1;
        if (k > MAX_K) k = MAX_K;
        return k;
    endfunction

    function automatic bit pair_above(input logic [31:0] da, input logic [31:0] ia,
                                      input logic [31:0] db, input logic [31:0] ib);
        return (da > db) || (da == db && ia > ib);
    endfunction

    function automatic int largest_pos();
        int m;
        m = 0;
        for (int i = 1; i < hold_cnt && i < MAX_K; i++)
            if (pair_above(hold_dist[i], hold_id[i], hold_dist[m], hold_id[m])) m = i;
        return m;
    endfunction

    // update the store copy and queue the snapshot an item causes
    task automatic track_item(input logic [1:0] op, input logic [31:0] cand_dist,
                              input logic [31:0] id);
        logic [31:0] sd [MAX_K];
        logic [31:0] si [MAX_K];
        snap_entry_t e;
        int          k;
        int          m;
        int          n;
        int          j;
        logic        full;
        logic [31:0] kth;
        k = kept_k();
        case (op)
            tkps_pkg::OP_QUERY: begin
                hold_cnt = 0;
            end
            tkps_pkg::OP_CAND: begin
                if (hold_cnt < k && hold_cnt < MAX_K) begin
                    hold_dist[hold_cnt] = cand_dist;
                    hold_id[hold_cnt]   = id;
                    hold_cnt++;
                end else if (hold_cnt > 0) begin
                    m = largest_pos();
                    if (cand_dist < hold_dist[m]) begin
                        hold_dist[m] = cand_dist;
                        hold_id[m]   = id;
                    end
                end
            end
            tkps_pkg::OP_END: begin
                n = (hold_cnt > MAX_K) ? MAX_K : hold_cnt;
                if (n == 0) begin
                    e = '0;
                    e.is_last = 1'b1;
                    snapshot_q = {snapshot_q, e};
                end else begin
                    // insertion sort by (distance, id)
                    for (int i = 0; i < n; i++) begin
                        j = i;
                        while (j > 0 && pair_above(sd[j-1], si[j-1], hold_dist[i], hold_id[i]))
                        begin
                            sd[j] = sd[j-1];
                            si[j] = si[j-1];
                            j--;
                        end
                        sd[j] = hold_dist[i];
                        si[j] = hold_id[i];
                    end
                    full = (hold_cnt >= k);
                    kth  = full ? sd[n-1] : 32'd0;
                    for (int i = 0; i < n; i++) begin
                        e.kth     = kth;
                        e.full    = full;
                        e.rank    = i[3:0];
                        e.id      = si[i];
                        e.valid   = 1'b1;
                        e.is_last = (i + 1 == n);
                        snapshot_q = {snapshot_q, e};
                    end
                end
            end
            default: ;
        endcase
    endtask

    // item driver
    always @(posedge aclk) begin
        probe_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) track_item(s_tuser, s_tdata[31:0], s_tdata[63:32]);
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    it = item_q.pop_front();
                    s_tuser  <= it.op;
                    s_tdata  <= {it.id, it.cand_dist};
                    s_tvalid <= 1'b1;
                    tx_gap   = tx_steady ? 0 : pick_idle();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin
        snap_entry_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (snapshot_q.size() == 0) begin
                note_mismatch("result transaction with nothing expected");
            end else begin
                want = snapshot_q.pop_front();
                if (m_tdata[31:0] !== want.kth)
                    note_mismatch($sformatf("kth_distance %h want %h", m_tdata[31:0], want.kth));
                if (m_tuser[0] !== want.full)
                    note_mismatch($sformatf("store_full %b want %b", m_tuser[0], want.full));
                if (m_tdata[35:32] !== want.rank)
                    note_mismatch($sformatf("entry_rank %0d want %0d", m_tdata[35:32], want.rank));
                if (m_tdata[67:36] !== want.id)
                    note_mismatch($sformatf("entry_id %h want %h", m_tdata[67:36], want.id));
                if (m_tuser[1] !== want.valid)
                    note_mismatch($sformatf("entry_valid %b want %b", m_tuser[1], want.valid));
                if (m_tlast !== want.is_last)
                    note_mismatch($sformatf("tlast %b want %b", m_tlast, want.is_last));
                if (m_tdata[71:68] !== 4'd0)
                    note_mismatch($sformatf("tdata pad %h not zero", m_tdata[71:68]));
            end
        end
        // random backpressure
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall = pick_idle();
        end
    end

    task automatic push_item(input logic [1:0] op, input logic [31:0] cand_dist,
                             input logic [31:0] id);
        probe_item_t it;
        it.op        = op;
        it.cand_dist = cand_dist;
        it.id        = id;
        item_q = {item_q, it};
    endtask

    task automatic write_top_k(input logic [4:0] val);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        k_reg = val;
        cfg_valid <= 1'b0;
    endtask

    // wait for every item and snapshot, then let the core settle
    task automatic wait_drained();
        while (item_q.size() != 0 || s_tvalid || snapshot_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_dist(input int mode);
        case (mode)
            0: return $urandom_range(0, 15);
            1: return $urandom();
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
    endfunction

    // stimulus sequencer
    initial begin
        logic [4:0] k_pick [8];
        int         cnt;
        int         r;
        int         mode;
        logic [31:0] id;
        k_pick = '{5'd16, 5'd31, 5'd17, 5'd2, 5'd0, 5'd5, 5'd1, 5'd0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty store, ignored op code, field extremes at the reset K
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        push_item(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(tkps_pkg::OP_CAND, 32'd0, 32'd0);
        push_item(tkps_pkg::OP_CAND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        push_item(tkps_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        wait_drained();

        // ties, strict replacement, replacement of the largest pair
        write_top_k(5'd3);
        push_item(tkps_pkg::OP_QUERY, 32'd0, 32'd0);
        push_item(tkps_pkg::OP_CAND, 32'd5, 32'd9);
        push_item(tkps_pkg::OP_CAND, 32'd5, 32'd2);
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        push_item(tkps_pkg::OP_CAND, 32'd7, 32'd1);
        push_item(tkps_pkg::OP_CAND, 32'd7, 32'd0);
        push_item(tkps_pkg::OP_CAND, 32'd6, 32'hFFFF_FFFF);
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        push_item(tkps_pkg::OP_CAND, 32'd5, 32'd0);
        push_item(OP_SPARE, 32'd0, 32'd0);
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        wait_drained();

        // K lowered with entries held
        write_top_k(5'd1);
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        push_item(tkps_pkg::OP_CAND, 32'd0, 32'd7);
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        wait_drained();

        // register zero saturates to one
        write_top_k(5'd0);
        push_item(tkps_pkg::OP_QUERY, 32'd0, 32'd0);
        push_item(tkps_pkg::OP_CAND, 32'd1, 32'd1);
        push_item(tkps_pkg::OP_CAND, 32'd1, 32'd0);
        push_item(tkps_pkg::OP_END, 32'd0, 32'd0);
        wait_drained();

        // random phases, mostly well-formed queries
        for (int ph = 0; ph < 8; ph++) begin
            write_top_k((ph == 4 || ph == 7) ? 5'($urandom_range(0, 31)) : k_pick[ph]);
            tx_steady = (ph == 3);
            rx_steady = (ph == 3 || ph == 6);
            if ($urandom_range(0, 99) < 85) push_item(tkps_pkg::OP_QUERY, $urandom(), $urandom());
            mode = $urandom_range(0, 2);
            cnt = 0;
            while (cnt < 17) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    push_item(OP_SPARE, $urandom(), $urandom());
                end else begin
                    if (r < 15) begin
                        push_item(tkps_pkg::OP_END, $urandom(), $urandom());
                    end else if (r < 18) begin
                        push_item(tkps_pkg::OP_QUERY, $urandom(), $urandom());
                    end else begin
                        if ($urandom_range(0, 7) == 0) mode = $urandom_range(0, 2);
                        id = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 7));
                        push_item(tkps_pkg::OP_CAND, rand_dist(mode), id);
                    end
                    cnt++;
                end
            end
            push_item(tkps_pkg::OP_END, $urandom(), $urandom());
            wait_drained();
        end

        if (mismatch_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
